FILE: src/button_debounce_autorepeat_core_defines.svh
// Assertion macros for the button debounce and auto-repeat core.
`ifndef BUTTON_DEBOUNCE_AUTOREPEAT_CORE_DEFINES_SVH
`define BUTTON_DEBOUNCE_AUTOREPEAT_CORE_DEFINES_SVH

`ifndef SYNTH

// check on every clock edge, skipped while reset is high
`define BDAR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check on every clock edge, reset included
`define BDAR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define BDAR_ASSERT(lbl, clk, rst, prop, msg)
`define BDAR_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: src/bdar_pkg.sv
// Types and constants for the button debounce and auto-repeat core.
`timescale 1ns / 1ps

package bdar_pkg;

   localparam int NUM_BUTTONS = 6;
   localparam int BTN_W       = 6;
   localparam int TIME_W      = 32;
   localparam int CFG_W       = 16;
   localparam int CSR_IDX_W   = 2;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 24;

   localparam logic [BTN_W-1:0] BTN_MASK = BTN_W'((1 << NUM_BUTTONS) - 1);

   // register indexes on the csr channel
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_INTERVAL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_DELAY      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_PERIOD     = 2'd2;

   localparam logic [CFG_W-1:0] DEBOUNCE_INTERVAL_RST = 16'd20;
   localparam logic [CFG_W-1:0] REPEAT_DELAY_RST      = 16'd400;
   localparam logic [CFG_W-1:0] REPEAT_PERIOD_RST     = 16'd250;

   // result beat, held_mask in the low bits
   typedef struct packed {
      logic [BTN_W-1:0] repeat_mask;
      logic [BTN_W-1:0] released_edges;
      logic [BTN_W-1:0] pressed_edges;
      logic [BTN_W-1:0] held_mask;
   } rsp_data_type;

endpackage

FILE: src/button_debounce_autorepeat_core.sv
// Button debouncer with two-phase release check and auto-repeat, one tick per beat.
//
//  channel | direction | handshake             | payload
//  req     | in        | req_tvalid/req_tready | req_tdata: button_levels
//  rsp     | out       | rsp_tvalid/rsp_tready | rsp_tdata: held, pressed, released, repeat
//  csr     | in        | csr_valid/csr_ready   | csr_index, csr_data
//
// One tick beat per clock while req_tready is high; each result is registered.
// All per-tick work sits between the state registers and the result register.
// A skid register holds one more result, so req_tready drops only when both are full.
// Synchronous active-high reset; csr writes are taken every cycle.
`timescale 1ns / 1ps
`include "button_debounce_autorepeat_core_defines.svh"

module button_debounce_autorepeat_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [bdar_pkg::REQ_DATA_W-1:0]     req_tdata,   // [5:0] button_levels
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [5:0] held_mask, [11:6] pressed_edges, [17:12] released_edges, [23:18] repeat_mask
   output logic [bdar_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bdar_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bdar_pkg::CFG_W-1:0]          csr_data
);

   import bdar_pkg::*;

   logic [CFG_W-1:0]  debounce_interval_ff, repeat_delay_ff, repeat_period_ff;

   logic [BTN_W-1:0]  held_ff, held_in;
   logic [BTN_W-1:0]  prev_held_ff;
   logic              check_phase_ff, check_phase_in;
   logic [BTN_W-1:0]  release_sample_ff, release_sample_in;
   logic [BTN_W-1:0]  held_at_sample_ff, held_at_sample_in;
   logic [TIME_W-1:0] now_ticks_ff;
   logic [TIME_W-1:0] last_check_time_ff, last_check_time_in;
   logic [TIME_W-1:0] last_press_time_ff, last_press_time_in;
   logic [TIME_W-1:0] last_repeat_time_ff, last_repeat_time_in;

   logic              out_valid_ff, out_valid_in;
   rsp_data_type      out_data_ff, out_data_in;
   logic              skid_valid_ff, skid_valid_in;
   rsp_data_type      skid_data_ff, skid_data_in;

   logic              req_acc, rsp_pop;
   logic [BTN_W-1:0]  levels, held_set, pressed, released, repeat_mask;
   logic [TIME_W-1:0] check_age, press_age, repeat_age;
   logic              check_due, rep_fire;
   rsp_data_type      result;

   assign req_tready = !skid_valid_ff;
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_pop    = out_valid_ff && rsp_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign csr_ready  = 1'b1;

   // per-tick datapath
   always_comb begin
      levels    = req_tdata[BTN_W-1:0] & BTN_MASK;
      held_set  = held_ff | (~levels & BTN_MASK);
      check_age = now_ticks_ff - last_check_time_ff;
      check_due = check_age >= {{(TIME_W-CFG_W){1'b0}}, debounce_interval_ff};

      held_in            = held_set;
      check_phase_in     = check_phase_ff;
      release_sample_in  = release_sample_ff;
      held_at_sample_in  = held_at_sample_ff;
      last_check_time_in = last_check_time_ff;
      if (check_due) begin
         last_check_time_in = now_ticks_ff;
         if (!check_phase_ff) begin
            release_sample_in = levels;
            held_at_sample_in = held_set;
            check_phase_in    = 1'b1;
         end else begin
            // clear released buttons only if the sample repeated and held stayed put
            if (held_set == held_at_sample_ff && release_sample_ff == levels)
               held_in = held_set & ~levels & BTN_MASK;
            check_phase_in = 1'b0;
         end
      end

      pressed  = ~prev_held_ff & held_in & BTN_MASK;
      released = prev_held_ff & ~held_in & BTN_MASK;

      last_press_time_in = (|pressed) ? now_ticks_ff : last_press_time_ff;
      press_age  = now_ticks_ff - last_press_time_in;
      repeat_age = now_ticks_ff - last_repeat_time_ff;
      rep_fire   = (press_age >= {{(TIME_W-CFG_W){1'b0}}, repeat_delay_ff}) &&
                   (repeat_age > {{(TIME_W-CFG_W){1'b0}}, repeat_period_ff});
      repeat_mask         = rep_fire ? held_in : '0;
      last_repeat_time_in = rep_fire ? now_ticks_ff : last_repeat_time_ff;

      result.held_mask      = held_in;
      result.pressed_edges  = pressed;
      result.released_edges = released;
      result.repeat_mask    = repeat_mask;
   end

   // result register plus skid
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (rsp_pop) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (req_acc) begin
         if (!out_valid_ff || rsp_pop) begin
            out_data_in  = result;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = result;
            skid_valid_in = 1'b1;
         end
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_interval_ff <= DEBOUNCE_INTERVAL_RST;
         repeat_delay_ff      <= REPEAT_DELAY_RST;
         repeat_period_ff     <= REPEAT_PERIOD_RST;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_DEBOUNCE_INTERVAL)
            debounce_interval_ff <= csr_data;
         else if (csr_index == CSR_REPEAT_DELAY)
            repeat_delay_ff <= csr_data;
         else if (csr_index == CSR_REPEAT_PERIOD)
            repeat_period_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff             <= '0;
         prev_held_ff        <= '0;
         check_phase_ff      <= 1'b0;
         release_sample_ff   <= '0;
         held_at_sample_ff   <= '0;
         now_ticks_ff        <= '0;
         last_check_time_ff  <= '0;
         last_press_time_ff  <= '0;
         last_repeat_time_ff <= '0;
      end else if (req_acc) begin
         held_ff             <= held_in;
         prev_held_ff        <= held_in;
         check_phase_ff      <= check_phase_in;
         release_sample_ff   <= release_sample_in;
         held_at_sample_ff   <= held_at_sample_in;
         now_ticks_ff        <= now_ticks_ff + 1'b1;
         last_check_time_ff  <= last_check_time_in;
         last_press_time_ff  <= last_press_time_in;
         last_repeat_time_ff <= last_repeat_time_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   `BDAR_ASSERT(a_skid_needs_out, clock, reset, skid_valid_ff |-> out_valid_ff, "skid full with empty result register")
   `BDAR_ASSERT(a_edges_disjoint, clock, reset, out_valid_ff |-> ((out_data_ff.pressed_edges & out_data_ff.released_edges) == '0), "button both pressed and released")
   `BDAR_ASSERT(a_repeat_is_held, clock, reset, (out_valid_ff && out_data_ff.repeat_mask != '0) |-> (out_data_ff.repeat_mask == out_data_ff.held_mask), "repeat mask differs from held mask")
   `BDAR_ASSERT(a_tick_advance, clock, reset, (req_acc && !reset) |=> (now_ticks_ff == $past(now_ticks_ff) + 1'b1), "tick count did not advance")
   `BDAR_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid, "result valid right after reset")

endmodule

FILE: verif/tb_button_debounce_autorepeat_core.sv
// Self-checking testbench for the button debounce and auto-repeat core.
`timescale 1ns / 1ps

module tb_button_debounce_autorepeat_core;
   import bdar_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 2'd3;
   localparam int CYCLE_LIMIT = 300000;

   typedef enum int { IDLE_SENDER_LIGHT, IDLE_SENDER_HEAVY, IDLE_NONE } idle_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;     // [5:0] button_levels
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // [5:0] held_mask, [11:6] pressed_edges, [17:12] released_edges, [23:18] repeat_mask
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0] csr_data = '0;

   button_debounce_autorepeat_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // debouncer model state
   logic [CFG_W-1:0] debounce_ticks, hold_off_ticks, period_ticks;
   logic [BTN_W-1:0] held_st, prev_held_st, sampled_released, held_at_check;
   logic             second_pass;
   logic [TIME_W-1:0] now_tick, last_check_tick, last_press_tick, last_repeat_tick;

   logic [BTN_W-1:0] levels_to_send[$];
   rsp_data_type     expected_results[$];
   idle_mode_type    idle_mode = IDLE_SENDER_LIGHT;
   int unsigned      errors = 0, ticks_sent = 0, results_seen = 0, repeats_seen = 0;
   int unsigned      cycles = 0;

   // advance the debouncer by one tick
   function automatic rsp_data_type advance_tick(input logic [BTN_W-1:0] levels);
      rsp_data_type     r;
      logic [BTN_W-1:0] rise, fall, rep;
      logic [TIME_W-1:0] t;
      t = now_tick;
      rep = '0;
      held_st = held_st | (~levels & BTN_MASK);
      if (TIME_W'(t - last_check_tick) >= TIME_W'(debounce_ticks)) begin
         last_check_tick = t;
         if (!second_pass) begin
            sampled_released = levels;
            held_at_check = held_st;
            second_pass = 1'b1;
         end else begin
            if (held_st == held_at_check && sampled_released == levels)
               held_st = held_st & ~levels & BTN_MASK;
            second_pass = 1'b0;
         end
      end
      rise = ~prev_held_st & held_st & BTN_MASK;
      fall = prev_held_st & ~held_st & BTN_MASK;
      prev_held_st = held_st;
      if (rise != '0)
         last_press_tick = t;
      if (TIME_W'(t - last_press_tick) >= TIME_W'(hold_off_ticks) &&
          TIME_W'(t - last_repeat_tick) > TIME_W'(period_ticks)) begin
         rep = held_st;
         last_repeat_tick = t;
      end
      now_tick = t + 1;
      r.held_mask = held_st;
      r.pressed_edges = rise;
      r.released_edges = fall;
      r.repeat_mask = rep;
      return r;
   endfunction

   function automatic bit roll(input int unsigned pct);
      return $urandom_range(0, 99) < pct;
   endfunction

   task automatic report_mismatch(input string what, input logic [BTN_W-1:0] got,
                                  input logic [BTN_W-1:0] want);
      $display("result %0d %s: got %h expected %h", results_seen, what, got, want);
      errors++;
   endtask

   // driver: one tick beat per handshake, prediction at acceptance
   always @(posedge clock) begin : driver
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_results.push_back(advance_tick(req_tdata[BTN_W-1:0]));
            ticks_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (levels_to_send.size() > 0 &&
                !(idle_mode == IDLE_SENDER_LIGHT && roll(11)) &&
                !(idle_mode == IDLE_SENDER_HEAVY && roll(88))) begin
               req_tvalid <= 1'b1;
               req_tdata <= {{(REQ_DATA_W-BTN_W){1'b0}}, levels_to_send.pop_front()};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver stalls
   always @(posedge clock) begin : sink
      if (idle_mode == IDLE_SENDER_LIGHT)
         rsp_tready <= !roll(88);
      else if (idle_mode == IDLE_SENDER_HEAVY)
         rsp_tready <= !roll(11);
      else
         rsp_tready <= 1'b1;
   end

   always @(posedge clock) begin : monitor
      rsp_data_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_data_type'(rsp_tdata);
         if (expected_results.size() == 0) begin
            $display("result %0d arrived with nothing outstanding: %h", results_seen, rsp_tdata);
            errors++;
         end else begin
            want = expected_results.pop_front();
            if (got.held_mask !== want.held_mask)
               report_mismatch("held_mask", got.held_mask, want.held_mask);
            if (got.pressed_edges !== want.pressed_edges)
               report_mismatch("pressed_edges", got.pressed_edges, want.pressed_edges);
            if (got.released_edges !== want.released_edges)
               report_mismatch("released_edges", got.released_edges, want.released_edges);
            if (got.repeat_mask !== want.repeat_mask)
               report_mismatch("repeat_mask", got.repeat_mask, want.repeat_mask);
            if (want.repeat_mask != '0)
               repeats_seen++;
         end
         results_seen++;
      end
   end

   always @(posedge clock) begin : watchdog
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycles, expected_results.size());
         $display("button_debounce_autorepeat_core: mismatch");
         $finish;
      end
   end

   // wait until every queued tick has produced its result; checked at the
   // falling edge so driver and monitor updates of the rising edge have settled
   task automatic drain_results();
      do @(negedge clock);
      while (levels_to_send.size() != 0 || req_tvalid || expected_results.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_DEBOUNCE_INTERVAL: debounce_ticks = val;
         CSR_REPEAT_DELAY:      hold_off_ticks = val;
         CSR_REPEAT_PERIOD:     period_ticks = val;
         default: ;
      endcase
   endtask

   task automatic set_timing(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] dly,
                             input logic [CFG_W-1:0] per);
      write_reg(CSR_DEBOUNCE_INTERVAL, deb);
      write_reg(CSR_REPEAT_DELAY, dly);
      write_reg(CSR_REPEAT_PERIOD, per);
   endtask

   // press-and-hold runs with contact bounce, then quiet runs, plus some raw noise
   task automatic queue_button_activity(input int n_ticks, input int max_hold,
                                        input int max_quiet);
      int               queued, hold_len, quiet_len;
      logic [BTN_W-1:0] mask, lv;
      queued = 0;
      while (queued < n_ticks) begin
         if (roll(12)) begin
            levels_to_send.push_back(BTN_W'($urandom));
            queued++;
         end else begin
            mask = BTN_W'($urandom_range(1, 63));
            hold_len = $urandom_range(1, max_hold);
            quiet_len = $urandom_range(1, max_quiet);
            // keep the run inside the requested tick count
            if (hold_len > n_ticks - queued)
               hold_len = n_ticks - queued;
            if (quiet_len > n_ticks - queued - hold_len)
               quiet_len = n_ticks - queued - hold_len;
            repeat (hold_len) begin
               lv = ~mask;
               if (roll(15))
                  lv ^= BTN_W'(1 << $urandom_range(0, BTN_W-1));
               levels_to_send.push_back(lv);
               queued++;
            end
            repeat (quiet_len) begin
               lv = BTN_MASK;
               if (roll(8))
                  lv ^= BTN_W'(1 << $urandom_range(0, BTN_W-1));
               levels_to_send.push_back(lv);
               queued++;
            end
         end
      end
   endtask

   initial begin : stimulus
      logic [BTN_W-1:0] directed_levels[$];
      debounce_ticks = DEBOUNCE_INTERVAL_RST;
      hold_off_ticks = REPEAT_DELAY_RST;
      period_ticks = REPEAT_PERIOD_RST;
      held_st = '0;
      prev_held_st = '0;
      sampled_released = '0;
      held_at_check = '0;
      second_pass = 1'b0;
      now_tick = '0;
      last_check_tick = '0;
      last_press_tick = '0;
      last_repeat_tick = '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset timing: all released, all pressed, each button alone, alternating bits
      directed_levels = '{6'h3F, 6'h3F, 6'h00, 6'h00, 6'h3F, 6'h3E, 6'h3D, 6'h3B,
                          6'h37, 6'h2F, 6'h1F, 6'h15, 6'h2A, 6'h3F, 6'h3F, 6'h00,
                          6'h3F, 6'h3F, 6'h3F, 6'h3F};
      foreach (directed_levels[i])
         levels_to_send.push_back(directed_levels[i]);
      queue_button_activity(100, 30, 60);
      drain_results();

      // zero interval and zero repeat timing; a write to the unused index is dropped
      write_reg(CSR_UNUSED_INDEX, CFG_W'($urandom));
      set_timing(16'd0, 16'd0, 16'd0);
      queue_button_activity(100, 8, 8);
      drain_results();

      idle_mode = IDLE_SENDER_HEAVY;
      set_timing(16'd1, 16'd5, 16'd3);
      queue_button_activity(100, 12, 10);
      drain_results();

      // maximum timing: releases and repeats cannot happen in this window
      set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
      queue_button_activity(60, 10, 10);
      drain_results();

      idle_mode = IDLE_NONE;
      set_timing(16'd4, 16'd30, 16'd6);
      queue_button_activity(75, 60, 20);
      drain_results();
      queue_button_activity(75, 60, 20);
      drain_results();

      set_timing(16'd2, 16'd40, 16'd10);
      queue_button_activity(100, 80, 15);
      drain_results();
      repeat (5) @(posedge clock);

      $display("%0d ticks over six timing settings, %0d results checked, %0d with repeat",
               ticks_sent, results_seen, repeats_seen);
      if (errors == 0)
         $display("button_debounce_autorepeat_core: match");
      else
         $display("button_debounce_autorepeat_core: mismatch");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+src
src/bdar_pkg.sv
src/button_debounce_autorepeat_core.sv
verif/tb_button_debounce_autorepeat_core.sv
